[design/gnc_pkg.sv]
// Shared widths, stage numbering and codes for the gradient noise chunk pixel core.
// No dependencies; every other file of the block refers to this package.
package gnc_pkg;

    localparam int MAX_SIZE_LOG2_DEF = 6;
    localparam int FRAC_BITS_DEF     = 16;

    localparam int OFS_W     = 6;
    localparam int NOISE_W   = 18;
    localparam int PIX_W     = 12;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int SIZE_W    = 3;

    localparam logic [SIZE_W-1:0] SIZE_LOG2_RST = 3'd4;

    // pipeline stage numbers
    localparam int ST_IN        = 0;
    localparam int ST_FADE_SQ   = 1;
    localparam int ST_FADE_CUBE = 2;
    localparam int ST_FADE_MUL  = 3;
    localparam int ST_FADE_RND  = 4;
    localparam int ST_LERP1_MUL = 5;
    localparam int ST_LERP1_ADD = 6;
    localparam int ST_LERP2_MUL = 7;
    localparam int ST_LERP2_ADD = 8;
    localparam int ST_OUT       = 9;
    localparam int NUM_ST       = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEED = 2'd0,
        REG_LEFT = 2'd1,
        REG_TOP  = 2'd2,
        REG_SIZE = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        GRAD_POS_X = 2'd0,
        GRAD_POS_Y = 2'd1,
        GRAD_NEG_X = 2'd2,
        GRAD_NEG_Y = 2'd3
    } grad_code_t;

endpackage

[design/gnc_ctrl.sv]
// Valid bits and per-stage load enables for the noise pipeline.
// Depends on gnc_pkg for the stage count.
module gnc_ctrl
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [gnc_pkg::NUM_ST-1:0] ld
);

    logic [gnc_pkg::NUM_ST-1:0] vld_reg;
    logic [gnc_pkg::NUM_ST-1:0] vld_next;

    always_comb
    begin
        ld[gnc_pkg::NUM_ST-1] = !vld_reg[gnc_pkg::NUM_ST-1] || !out_stall;
        for (int i = gnc_pkg::NUM_ST - 2; i >= 0; i--)
        begin
            ld[i] = !vld_reg[i] || ld[i+1];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (ld[0])
        begin
            vld_next[0] = in_valid;
        end
        for (int i = 1; i < gnc_pkg::NUM_ST; i++)
        begin
            if (ld[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_stall  = !ld[0];
    assign out_valid = vld_reg[gnc_pkg::NUM_ST-1];

endmodule

[design/gnc_grad.sv]
// Corner gradient selection and scaled corner dot products, delayed to the lerp stage.
// Depends on gnc_pkg for the offset width and gradient codes.
module gnc_grad
#(
    parameter int MAX_SIZE_LOG2 = gnc_pkg::MAX_SIZE_LOG2_DEF,
    parameter int FRAC_BITS     = gnc_pkg::FRAC_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic [3:0]                           ld,
    input  logic [$clog2(MAX_SIZE_LOG2+1)-1:0]   s,
    input  logic [gnc_pkg::OFS_W-1:0]            dx,
    input  logic [gnc_pkg::OFS_W-1:0]            dy,
    input  logic [31:0]                          base,
    output logic signed [FRAC_BITS+1:0]          lt,
    output logic signed [FRAC_BITS+1:0]          rt,
    output logic signed [FRAC_BITS+1:0]          lb,
    output logic signed [FRAC_BITS+1:0]          rb
);

    localparam int CW  = FRAC_BITS + 2;
    localparam int SHW = $clog2(FRAC_BITS + 1);
    localparam logic signed [CW-1:0] ONE = CW'(1 << FRAC_BITS);

    logic [SHW-1:0]        sh;
    logic signed [CW-1:0]  xq;
    logic signed [CW-1:0]  yq;
    logic signed [CW-1:0]  c_next [4];
    logic signed [CW-1:0]  c_reg  [4][4];

    function automatic logic signed [CW-1:0] gdot(input logic [31:0] v,
                                                  input logic signed [CW-1:0] ox,
                                                  input logic signed [CW-1:0] oy);
        gnc_pkg::grad_code_t c;
        if (v[31] && (v[1:0] != 2'd0))
        begin
            c = gnc_pkg::GRAD_NEG_Y;
        end
        else
        begin
            c = gnc_pkg::grad_code_t'(v[1:0]);
        end
        case (c)
            gnc_pkg::GRAD_POS_X: gdot = ox;
            gnc_pkg::GRAD_POS_Y: gdot = oy;
            gnc_pkg::GRAD_NEG_X: gdot = -ox;
            default:             gdot = -oy;
        endcase
    endfunction

    always_comb
    begin
        sh = SHW'(FRAC_BITS) - SHW'(s);
        xq = CW'(dx) << sh;
        yq = CW'(dy) << sh;
        c_next[0] = gdot(base,          xq,       -yq);
        c_next[1] = gdot(base + 32'd2,  xq - ONE, -yq);
        c_next[2] = gdot(base + 32'd1,  xq,       ONE - yq);
        c_next[3] = gdot(base + 32'd3,  xq - ONE, ONE - yq);
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            c_reg[0] <= c_next;
        end
        for (int k = 1; k < 4; k++)
        begin
            if (ld[k])
            begin
                c_reg[k] <= c_reg[k-1];
            end
        end
    end

    assign lt = c_reg[3][0];
    assign rt = c_reg[3][1];
    assign lb = c_reg[3][2];
    assign rb = c_reg[3][3];

endmodule

[design/gnc_fade.sv]
// Quintic fade 6t^5-15t^4+10t^3 of d/2^s, rounded half up to FRAC_BITS; four stages.
// Depends on gnc_pkg for the offset width.
module gnc_fade
#(
    parameter int MAX_SIZE_LOG2 = gnc_pkg::MAX_SIZE_LOG2_DEF,
    parameter int FRAC_BITS     = gnc_pkg::FRAC_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic [3:0]                           ld,
    input  logic [gnc_pkg::OFS_W-1:0]            d,
    input  logic [$clog2(MAX_SIZE_LOG2+1)-1:0]   s,
    output logic [FRAC_BITS:0]                   fq
);

    localparam int SW  = $clog2(MAX_SIZE_LOG2 + 1);
    localparam int DW  = gnc_pkg::OFS_W;
    localparam int BW  = 2 * MAX_SIZE_LOG2 + 4;
    localparam int FW  = 3 * DW + BW;
    localparam int RW  = FW + 1;
    localparam int SHW = $clog2(5 * MAX_SIZE_LOG2 + FRAC_BITS + 1);

    logic [DW-1:0]      d1_reg;
    logic [2*DW-1:0]    d2_reg;
    logic [SW-1:0]      s1_reg;
    logic [3*DW-1:0]    d3_reg;
    logic [BW-1:0]      br_reg;
    logic [BW-1:0]      br_next;
    logic [SW-1:0]      s2_reg;
    logic [FW-1:0]      f_reg;
    logic [SW-1:0]      s3_reg;
    logic [FRAC_BITS:0] fq_reg;
    logic [FRAC_BITS:0] fq_next;
    logic [SHW-1:0]     sh;
    logic [SHW-1:0]     k;
    logic [RW-1:0]      rnd;

    // 10*S^2 - 15*d*S + 6*d^2, always positive, so modulo arithmetic is exact
    always_comb
    begin
        br_next = (BW'(d2_reg) * BW'(6))
                - ((BW'(d1_reg) << s1_reg) * BW'(15))
                + (BW'(10) << {s1_reg, 1'b0});
    end

    always_comb
    begin
        sh  = (SHW'(s3_reg) << 2) + SHW'(s3_reg);
        k   = sh - SHW'(FRAC_BITS);
        rnd = (RW'(f_reg) + (RW'(1) << (k - SHW'(1)))) >> k;
        if (sh > SHW'(FRAC_BITS))
        begin
            fq_next = (FRAC_BITS+1)'(rnd);
        end
        else
        begin
            fq_next = (FRAC_BITS+1)'(f_reg) << (SHW'(FRAC_BITS) - sh);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            d1_reg <= d;
            d2_reg <= (2*DW)'(d) * (2*DW)'(d);
            s1_reg <= s;
        end
        if (ld[1])
        begin
            d3_reg <= (3*DW)'(d2_reg) * (3*DW)'(d1_reg);
            br_reg <= br_next;
            s2_reg <= s1_reg;
        end
        if (ld[2])
        begin
            f_reg  <= FW'(d3_reg) * FW'(br_reg);
            s3_reg <= s2_reg;
        end
        if (ld[3])
        begin
            fq_reg <= fq_next;
        end
    end

    assign fq = fq_reg;

endmodule

[design/gnc_lerp.sv]
// Two-stage linear interpolation a + round((b-a)*f / 2^FRAC_BITS), ties rounded upward.
// Depends on gnc_pkg only for the parameter defaults.
module gnc_lerp
#(
    parameter int W         = gnc_pkg::FRAC_BITS_DEF + 2,
    parameter int FRAC_BITS = gnc_pkg::FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 ld_mul,
    input  logic                 ld_add,
    input  logic signed [W-1:0]  a,
    input  logic signed [W-1:0]  b,
    input  logic [FRAC_BITS:0]   f,
    output logic signed [W-1:0]  y
);

    localparam int PW = W + FRAC_BITS + 3;
    localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

    logic signed [W:0]           diff;
    logic signed [FRAC_BITS+1:0] fs;
    logic signed [PW-1:0]        prod_next;
    logic signed [PW-1:0]        prod_reg;
    logic signed [PW-1:0]        rnd;
    logic signed [W-1:0]         a_reg;
    logic signed [W-1:0]         y_reg;

    always_comb
    begin
        diff      = (W+1)'(b) - (W+1)'(a);
        fs        = $signed({1'b0, f});
        prod_next = PW'(diff) * PW'(fs);
        rnd       = (prod_reg + HALF) >>> FRAC_BITS;
    end

    always_ff @(posedge clk)
    begin
        if (ld_mul)
        begin
            prod_reg <= prod_next;
            a_reg    <= a;
        end
        if (ld_add)
        begin
            y_reg <= a_reg + W'(rnd);
        end
    end

    assign y = y_reg;

endmodule

[design/gradient_noise_chunk_pixel_core.sv]
// 2D gradient noise over one chunk, one pixel beat per clock on coord_valid/coord_stall
// unless stalled; results on noise_valid/noise_stall through a ten-stage pipeline (input,
// four fade multiply/round stages, two stages per lerp level, saturating output register).
// Throughput is one beat per cycle while noise_stall is low; a stage holds only while it
// and every later stage are full, so bubbles are absorbed. Registers (seed, chunk_left,
// chunk_top, size_log2) are written via cfg_*, by the user only while idle; not enforced.
module gradient_noise_chunk_pixel_core
#(
    parameter int MAX_SIZE_LOG2 = gnc_pkg::MAX_SIZE_LOG2_DEF,
    parameter int FRAC_BITS     = gnc_pkg::FRAC_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gnc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gnc_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              coord_valid,
    output logic                              coord_stall,
    input  logic [gnc_pkg::OFS_W-1:0]         offset_x,
    input  logic [gnc_pkg::OFS_W-1:0]         offset_y,
    output logic                              noise_valid,
    input  logic                              noise_stall,
    output logic signed [gnc_pkg::NOISE_W-1:0] noise_value,
    output logic [gnc_pkg::PIX_W-1:0]         pixel_index
);

    localparam int SW  = $clog2(MAX_SIZE_LOG2 + 1);
    localparam int CW  = FRAC_BITS + 2;
    localparam int PXW = gnc_pkg::OFS_W + MAX_SIZE_LOG2;
    localparam int EW  = (CW > gnc_pkg::NOISE_W) ? CW : gnc_pkg::NOISE_W;
    localparam logic signed [CW-1:0] ONE = CW'(1 << FRAC_BITS);

    logic [31:0]                    seed_reg;
    logic [31:0]                    left_reg;
    logic [31:0]                    top_reg;
    logic [gnc_pkg::SIZE_W-1:0]     size_reg;

    logic [gnc_pkg::NUM_ST-1:0]     ld;

    logic [SW-1:0]                  s_next;
    logic [gnc_pkg::OFS_W-1:0]      msk;
    logic [gnc_pkg::OFS_W-1:0]      dx_next;
    logic [gnc_pkg::OFS_W-1:0]      dy_next;
    logic [PXW-1:0]                 pix_full;
    logic [31:0]                    base_next;

    logic [SW-1:0]                  s0_reg;
    logic [gnc_pkg::OFS_W-1:0]      dx0_reg;
    logic [gnc_pkg::OFS_W-1:0]      dy0_reg;
    logic [31:0]                    base0_reg;
    logic [gnc_pkg::PIX_W-1:0]      pix_reg [gnc_pkg::NUM_ST];

    logic signed [CW-1:0]           lt;
    logic signed [CW-1:0]           rt;
    logic signed [CW-1:0]           lb;
    logic signed [CW-1:0]           rb;
    logic [FRAC_BITS:0]             fx;
    logic [FRAC_BITS:0]             fy;
    logic [FRAC_BITS:0]             fy5_reg;
    logic [FRAC_BITS:0]             fy6_reg;
    logic signed [CW-1:0]           top_val;
    logic signed [CW-1:0]           bot_val;
    logic signed [CW-1:0]           tot;
    logic signed [CW-1:0]           sat;
    logic signed [EW-1:0]           sat_ext;
    logic signed [gnc_pkg::NOISE_W-1:0] noise_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
            left_reg <= '0;
            top_reg  <= '0;
            size_reg <= gnc_pkg::SIZE_LOG2_RST;
        end
        else if (cfg_valid)
        begin
            case (gnc_pkg::cfg_reg_t'(cfg_index))
                gnc_pkg::REG_SEED: seed_reg <= cfg_data;
                gnc_pkg::REG_LEFT: left_reg <= cfg_data;
                gnc_pkg::REG_TOP:  top_reg  <= cfg_data;
                gnc_pkg::REG_SIZE: size_reg <= cfg_data[gnc_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    gnc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (coord_valid),
        .in_stall  (coord_stall),
        .out_valid (noise_valid),
        .out_stall (noise_stall),
        .ld        (ld)
    );

    // input stage: clamp size, wrap offsets, gradient hash base, pixel index
    always_comb
    begin
        if (size_reg == '0)
        begin
            s_next = SW'(1);
        end
        else if (int'(size_reg) > MAX_SIZE_LOG2)
        begin
            s_next = SW'(MAX_SIZE_LOG2);
        end
        else
        begin
            s_next = SW'(size_reg);
        end
        for (int i = 0; i < gnc_pkg::OFS_W; i++)
        begin
            msk[i] = (i < int'(s_next));
        end
        dx_next   = offset_x & msk;
        dy_next   = offset_y & msk;
        pix_full  = (PXW'(dx_next) << s_next) + PXW'(dy_next);
        base_next = seed_reg - top_reg + {left_reg[30:0], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (ld[gnc_pkg::ST_IN])
        begin
            s0_reg               <= s_next;
            dx0_reg              <= dx_next;
            dy0_reg              <= dy_next;
            base0_reg            <= base_next;
            pix_reg[gnc_pkg::ST_IN] <= gnc_pkg::PIX_W'(pix_full);
        end
        for (int k = 1; k < gnc_pkg::NUM_ST; k++)
        begin
            if (ld[k])
            begin
                pix_reg[k] <= pix_reg[k-1];
            end
        end
    end

    gnc_grad #(.MAX_SIZE_LOG2(MAX_SIZE_LOG2), .FRAC_BITS(FRAC_BITS)) u_grad
    (
        .clk  (clk),
        .ld   (ld[gnc_pkg::ST_FADE_RND:gnc_pkg::ST_FADE_SQ]),
        .s    (s0_reg),
        .dx   (dx0_reg),
        .dy   (dy0_reg),
        .base (base0_reg),
        .lt   (lt),
        .rt   (rt),
        .lb   (lb),
        .rb   (rb)
    );

    gnc_fade #(.MAX_SIZE_LOG2(MAX_SIZE_LOG2), .FRAC_BITS(FRAC_BITS)) u_fade_x
    (
        .clk (clk),
        .ld  (ld[gnc_pkg::ST_FADE_RND:gnc_pkg::ST_FADE_SQ]),
        .d   (dx0_reg),
        .s   (s0_reg),
        .fq  (fx)
    );

    gnc_fade #(.MAX_SIZE_LOG2(MAX_SIZE_LOG2), .FRAC_BITS(FRAC_BITS)) u_fade_y
    (
        .clk (clk),
        .ld  (ld[gnc_pkg::ST_FADE_RND:gnc_pkg::ST_FADE_SQ]),
        .d   (dy0_reg),
        .s   (s0_reg),
        .fq  (fy)
    );

    gnc_lerp #(.W(CW), .FRAC_BITS(FRAC_BITS)) u_lerp_top
    (
        .clk    (clk),
        .ld_mul (ld[gnc_pkg::ST_LERP1_MUL]),
        .ld_add (ld[gnc_pkg::ST_LERP1_ADD]),
        .a      (lt),
        .b      (rt),
        .f      (fx),
        .y      (top_val)
    );

    gnc_lerp #(.W(CW), .FRAC_BITS(FRAC_BITS)) u_lerp_bot
    (
        .clk    (clk),
        .ld_mul (ld[gnc_pkg::ST_LERP1_MUL]),
        .ld_add (ld[gnc_pkg::ST_LERP1_ADD]),
        .a      (lb),
        .b      (rb),
        .f      (fx),
        .y      (bot_val)
    );

    always_ff @(posedge clk)
    begin
        if (ld[gnc_pkg::ST_LERP1_MUL])
        begin
            fy5_reg <= fy;
        end
        if (ld[gnc_pkg::ST_LERP1_ADD])
        begin
            fy6_reg <= fy5_reg;
        end
    end

    gnc_lerp #(.W(CW), .FRAC_BITS(FRAC_BITS)) u_lerp_tot
    (
        .clk    (clk),
        .ld_mul (ld[gnc_pkg::ST_LERP2_MUL]),
        .ld_add (ld[gnc_pkg::ST_LERP2_ADD]),
        .a      (top_val),
        .b      (bot_val),
        .f      (fy6_reg),
        .y      (tot)
    );

    // saturate to +/-1, then keep the low output bits
    always_comb
    begin
        if (tot > ONE)
        begin
            sat = ONE;
        end
        else if (tot < -ONE)
        begin
            sat = -ONE;
        end
        else
        begin
            sat = tot;
        end
        sat_ext = EW'(sat);
    end

    always_ff @(posedge clk)
    begin
        if (ld[gnc_pkg::ST_OUT])
        begin
            noise_reg <= sat_ext[gnc_pkg::NOISE_W-1:0];
        end
    end

    assign noise_value = noise_reg;
    assign pixel_index = pix_reg[gnc_pkg::ST_OUT];

endmodule

[design/gnc_checker.sv]
// Port-level checks for gradient_noise_chunk_pixel_core, attached by the bind below.
// Depends on gnc_pkg for the output width.
module gnc_checker
#(
    parameter int FRAC_BITS = gnc_pkg::FRAC_BITS_DEF
)
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               coord_valid,
    input logic                               coord_stall,
    input logic                               noise_valid,
    input logic                               noise_stall,
    input logic signed [gnc_pkg::NOISE_W-1:0] noise_value,
    input logic [gnc_pkg::PIX_W-1:0]          pixel_index
);

    localparam bit CHECK_RANGE = (FRAC_BITS <= gnc_pkg::NOISE_W - 2);
    localparam logic signed [gnc_pkg::NOISE_W-1:0] NOISE_LIM =
        CHECK_RANGE ? gnc_pkg::NOISE_W'(1 << FRAC_BITS) : '0;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        noise_valid && noise_stall |=> noise_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        noise_valid && noise_stall |=> $stable(noise_value) && $stable(pixel_index))
        else $error("result payload changed while stalled");

    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        coord_valid && (!noise_valid || !noise_stall) |-> !coord_stall)
        else $error("input stalled although the output side is free");

    a_noise_range: assert property (@(posedge clk) disable iff (!rst_n)
        noise_valid |-> !CHECK_RANGE ||
                        (noise_value <= NOISE_LIM && noise_value >= -NOISE_LIM))
        else $error("noise value outside saturation limits");

endmodule

bind gradient_noise_chunk_pixel_core gnc_checker #(.FRAC_BITS(FRAC_BITS)) u_gnc_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .coord_valid (coord_valid),
    .coord_stall (coord_stall),
    .noise_valid (noise_valid),
    .noise_stall (noise_stall),
    .noise_value (noise_value),
    .pixel_index (pixel_index)
);
